### sv/vgmp_pkg.sv
// vgmp_pkg: shared types and constants for the VGM command stream parser.
// No dependencies; compiled first.
`default_nettype none

package vgmp_pkg;

    localparam int unsigned RAM_BYTES_DEFAULT = 524288;
    localparam int unsigned FIFO_DEPTH        = 4;

    typedef enum logic [2:0] {
        KIND_REG_WRITE   = 3'd0,
        KIND_RAM_WRITE   = 3'd1,
        KIND_RAM_PRELOAD = 3'd2,
        KIND_END         = 3'd3,
        KIND_ERROR       = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_NOT_VGM      = 3'd1,
        ERR_WAIT         = 3'd2,
        ERR_REG_WRITE    = 3'd3,
        ERR_BLOCK        = 3'd4,
        ERR_BLOCK_LENGTH = 3'd5,
        ERR_COMMAND      = 3'd6,
        ERR_START        = 3'd7
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] sample_time;
        logic [31:0] address;
        logic [7:0]  value;
        logic [31:0] total_count;
        err_t        error_code;
        logic        run_last;
    } result_t;

    // Results produced by one input beat, in order: first, then second.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

### sv/vgmp_if.sv
// vgmp_if: valid/ready channel interfaces for file bytes and parser results.
// No dependencies.
`default_nettype none

interface vgmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final_byte;

    modport source (output valid, in_byte, is_final_byte, input ready);
    modport sink   (input valid, in_byte, is_final_byte, output ready);
endinterface

interface vgmp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] sample_time;
    logic [31:0] address;
    logic [7:0]  value;
    logic [31:0] total_count;
    logic [2:0]  error_code;
    logic        run_last;

    modport source (output valid, kind, sample_time, address, value, total_count,
                    error_code, run_last, input ready);
    modport sink   (input valid, kind, sample_time, address, value, total_count,
                    error_code, run_last, output ready);
endinterface

`default_nettype wire

### sv/vgmp_parser.sv
// vgmp_parser: per-byte VGM parse state and result generation, one beat per cycle while accept is high.
// Depends on vgmp_pkg.
`default_nettype none

module vgmp_parser #(
    parameter int unsigned RAM_BYTES = vgmp_pkg::RAM_BYTES_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      in_byte,
    input  wire logic            is_final_byte,
    output vgmp_pkg::push_t      push
);
    import vgmp_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR   = 4'd0,
        PH_SKIP  = 4'd1,
        PH_CMD   = 4'd2,
        PH_WAIT  = 4'd3,
        PH_REG   = 4'd4,
        PH_BMARK = 4'd5,
        PH_BTYPE = 4'd6,
        PH_BSIZE = 4'd7,
        PH_BADDR = 4'd8,
        PH_BDATA = 4'd9,
        PH_TAIL  = 4'd10
    } phase_t;

    localparam logic [7:0] CMD_END      = 8'h66;
    localparam logic [7:0] CMD_WAIT     = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL = 8'h63;
    localparam logic [7:0] CMD_REG      = 8'hC5;
    localparam logic [7:0] CMD_BLOCK    = 8'h67;
    localparam logic [7:0] BLOCK_MARK   = 8'h66;
    localparam logic [7:0] BLOCK_RAM    = 8'hE0;
    localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;
    localparam logic [31:0] POS_BODY    = 32'h0000_00FF;
    localparam logic [31:0] OFS_TOTAL   = 32'h0000_0018;
    localparam logic [31:0] OFS_START   = 32'h0000_0034;
    localparam logic [31:0] MIN_START   = 32'h0000_0038;
    localparam logic [16:0] WAIT_NTSC   = 17'd735;
    localparam logic [16:0] WAIT_PAL    = 17'd882;
    localparam logic [32:0] RamSize     = 33'(RAM_BYTES);
    localparam logic [7:0]  Magic [4]   = '{8'h56, 8'h67, 8'h6D, 8'h20};

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] sample_reg, sample_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  left_reg, left_next;
    logic [7:0]  btype_reg, btype_next;
    logic [31:0] bleft_reg, bleft_next;
    logic [31:0] baddr_reg, baddr_next;
    logic        initial_reg, initial_next;
    logic        preload_reg, preload_next;
    logic        done_reg, done_next;

    logic        ev_v, term_v, adv_v, cmd_v;
    kind_t       ev_kind, term_kind;
    err_t        term_err;
    logic [31:0] ev_addr;
    logic [7:0]  ev_val;
    logic [16:0] adv_amt;
    logic [31:0] idx, acc_or, start_calc;
    logic [32:0] adv_sum;
    result_t     r_ev, r_term;

    function automatic logic [31:0] place_byte(input logic [7:0] b, input logic [1:0] k);
        return {24'd0, b} << {k, 3'b000};
    endfunction

    assign idx = pos_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        start_next   = start_reg;
        acc_next     = acc_reg;
        left_next    = left_reg;
        btype_next   = btype_reg;
        bleft_next   = bleft_reg;
        baddr_next   = baddr_reg;
        initial_next = initial_reg;
        preload_next = preload_reg;
        done_next    = done_reg;
        ev_v         = 1'b0;
        ev_kind      = KIND_REG_WRITE;
        ev_addr      = '0;
        ev_val       = '0;
        term_v       = 1'b0;
        term_kind    = KIND_END;
        term_err     = ERR_NONE;
        adv_v        = 1'b0;
        adv_amt      = '0;
        cmd_v        = 1'b0;
        acc_or       = '0;
        start_calc   = '0;

        if (accept && !done_reg)
        begin
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 32'd1;

            if (is_final_byte && idx < POS_BODY)
            begin
                term_v    = 1'b1;
                term_kind = KIND_ERROR;
                term_err  = ERR_NOT_VGM;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR:
                    begin
                        if (idx < 32'd4 && in_byte != Magic[idx[1:0]])
                        begin
                            term_v    = 1'b1;
                            term_kind = KIND_ERROR;
                            term_err  = ERR_NOT_VGM;
                        end
                        else
                        begin
                            if (idx >= OFS_TOTAL && idx <= OFS_TOTAL + 32'd3)
                                total_next = total_reg | place_byte(in_byte, idx[1:0]);
                            if (idx == OFS_START)
                                acc_or = {24'd0, in_byte};
                            else if (idx > OFS_START && idx <= OFS_START + 32'd3)
                                acc_or = acc_reg | place_byte(in_byte, idx[1:0]);
                            else
                                acc_or = acc_reg;
                            acc_next = acc_or;
                            if (idx >= OFS_START + 32'd3)
                            begin
                                start_calc = OFS_START + acc_or;
                                start_next = start_calc;
                                acc_next   = '0;
                                if (start_calc < MIN_START)
                                begin
                                    term_v    = 1'b1;
                                    term_kind = KIND_ERROR;
                                    term_err  = ERR_START;
                                end
                                else
                                    phase_next = (start_calc == MIN_START) ? PH_CMD : PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        if (idx >= start_reg)
                        begin
                            phase_next = PH_CMD;
                            cmd_v      = 1'b1;
                        end
                    end
                    PH_CMD:
                        cmd_v = 1'b1;
                    PH_WAIT:
                    begin
                        acc_or    = acc_reg | place_byte(in_byte, 2'(3'd2 - left_reg));
                        acc_next  = acc_or;
                        left_next = left_reg - 3'd1;
                        if (left_reg == 3'd1)
                        begin
                            adv_v      = 1'b1;
                            adv_amt    = {1'b0, acc_or[15:0]};
                            phase_next = PH_CMD;
                        end
                    end
                    PH_REG:
                    begin
                        if (left_reg > 3'd1)
                        begin
                            acc_next  = {16'd0, acc_reg[7:0], in_byte};
                            left_next = left_reg - 3'd1;
                        end
                        else
                        begin
                            ev_v       = 1'b1;
                            ev_kind    = KIND_REG_WRITE;
                            ev_addr    = {16'd0, acc_reg[15:0]};
                            ev_val     = in_byte;
                            left_next  = '0;
                            phase_next = PH_CMD;
                        end
                    end
                    PH_BMARK:
                    begin
                        if (in_byte != BLOCK_MARK)
                        begin
                            term_v    = 1'b1;
                            term_kind = KIND_ERROR;
                            term_err  = ERR_BLOCK;
                        end
                        else
                            phase_next = PH_BTYPE;
                    end
                    PH_BTYPE:
                    begin
                        btype_next = in_byte;
                        phase_next = PH_BSIZE;
                        left_next  = 3'd4;
                        acc_next   = '0;
                    end
                    PH_BSIZE:
                    begin
                        acc_or    = acc_reg | place_byte(in_byte, 2'(3'd4 - left_reg));
                        acc_next  = acc_or;
                        left_next = left_reg - 3'd1;
                        if (left_reg == 3'd1)
                        begin
                            if (acc_or < 32'd4)
                            begin
                                term_v    = 1'b1;
                                term_kind = KIND_ERROR;
                                term_err  = ERR_BLOCK_LENGTH;
                            end
                            else
                            begin
                                bleft_next = acc_or - 32'd4;
                                phase_next = PH_BADDR;
                                left_next  = 3'd4;
                                acc_next   = '0;
                            end
                        end
                    end
                    PH_BADDR:
                    begin
                        acc_or    = acc_reg | place_byte(in_byte, 2'(3'd4 - left_reg));
                        acc_next  = acc_or;
                        left_next = left_reg - 3'd1;
                        if (left_reg == 3'd1)
                        begin
                            baddr_next   = acc_or;
                            acc_next     = '0;
                            preload_next = 1'b0;
                            if (btype_reg == BLOCK_RAM)
                            begin
                                if (initial_reg && sample_reg == '0
                                    && {1'b0, acc_or} < RamSize
                                    && {1'b0, bleft_reg} <= RamSize - {1'b0, acc_or})
                                    preload_next = 1'b1;
                                else
                                    initial_next = 1'b0;
                            end
                            phase_next = (bleft_reg == '0) ? PH_CMD : PH_BDATA;
                        end
                    end
                    PH_BDATA:
                    begin
                        if (btype_reg == BLOCK_RAM)
                        begin
                            ev_v    = 1'b1;
                            ev_kind = preload_reg ? KIND_RAM_PRELOAD : KIND_RAM_WRITE;
                            ev_addr = baddr_reg;
                            ev_val  = in_byte;
                        end
                        baddr_next = baddr_reg + 32'd1;
                        bleft_next = bleft_reg - 32'd1;
                        if (bleft_reg == 32'd1)
                            phase_next = PH_CMD;
                    end
                    PH_TAIL:
                    begin
                        if (idx >= POS_BODY)
                        begin
                            term_v    = 1'b1;
                            term_kind = KIND_END;
                        end
                    end
                    default:
                    begin
                        term_v    = 1'b1;
                        term_kind = KIND_ERROR;
                        term_err  = ERR_COMMAND;
                    end
                endcase

                if (cmd_v)
                begin
                    case (in_byte) inside
                        CMD_END:
                        begin
                            if (idx >= POS_BODY)
                            begin
                                term_v    = 1'b1;
                                term_kind = KIND_END;
                            end
                            else
                                phase_next = PH_TAIL;
                        end
                        CMD_WAIT:
                        begin
                            phase_next = PH_WAIT;
                            left_next  = 3'd2;
                            acc_next   = '0;
                        end
                        CMD_WAIT_NTSC:
                        begin
                            adv_v   = 1'b1;
                            adv_amt = WAIT_NTSC;
                        end
                        CMD_WAIT_PAL:
                        begin
                            adv_v   = 1'b1;
                            adv_amt = WAIT_PAL;
                        end
                        [8'h70:8'h7F]:
                        begin
                            adv_v   = 1'b1;
                            adv_amt = 17'(in_byte[3:0]) + 17'd1;
                        end
                        CMD_REG:
                        begin
                            initial_next = 1'b0;
                            phase_next   = PH_REG;
                            left_next    = 3'd3;
                            acc_next     = '0;
                        end
                        CMD_BLOCK:
                            phase_next = PH_BMARK;
                        default:
                        begin
                            term_v    = 1'b1;
                            term_kind = KIND_ERROR;
                            term_err  = ERR_COMMAND;
                        end
                    endcase
                end

                // final byte closes the stream according to where parsing stopped
                if (!term_v && is_final_byte)
                begin
                    term_v = 1'b1;
                    case (phase_next)
                        PH_CMD, PH_SKIP, PH_TAIL:
                            term_kind = KIND_END;
                        PH_WAIT:
                        begin
                            term_kind = KIND_ERROR;
                            term_err  = ERR_WAIT;
                        end
                        PH_REG:
                        begin
                            term_kind = KIND_ERROR;
                            term_err  = ERR_REG_WRITE;
                        end
                        PH_BMARK, PH_BTYPE, PH_BSIZE:
                        begin
                            term_kind = KIND_ERROR;
                            term_err  = ERR_BLOCK;
                        end
                        PH_BADDR, PH_BDATA:
                        begin
                            term_kind = KIND_ERROR;
                            term_err  = ERR_BLOCK_LENGTH;
                        end
                        default:
                        begin
                            term_kind = KIND_ERROR;
                            term_err  = ERR_NOT_VGM;
                        end
                    endcase
                end
            end
            done_next = term_v;
        end
    end

    // saturating sample clock
    assign adv_sum = {1'b0, sample_reg} + 33'(adv_amt);

    always_comb
    begin
        if (adv_v)
            sample_next = adv_sum[32] ? 32'hFFFF_FFFF : adv_sum[31:0];
        else
            sample_next = sample_reg;
    end

    always_comb
    begin
        r_ev.kind           = ev_kind;
        r_ev.sample_time    = sample_next;
        r_ev.address        = ev_addr;
        r_ev.value          = ev_val;
        r_ev.total_count    = '0;
        r_ev.error_code     = ERR_NONE;
        r_ev.run_last       = !term_v;

        r_term.kind          = term_kind;
        r_term.sample_time   = sample_next;
        r_term.address       = '0;
        r_term.value         = '0;
        r_term.total_count   = (term_kind == KIND_END) ? total_reg : '0;
        r_term.error_code    = term_err;
        r_term.run_last      = 1'b1;

        push.count  = {1'b0, ev_v} + {1'b0, term_v};
        push.first  = ev_v ? r_ev : r_term;
        push.second = r_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR;
            pos_reg     <= '0;
            total_reg   <= '0;
            start_reg   <= '0;
            sample_reg  <= '0;
            acc_reg     <= '0;
            left_reg    <= '0;
            btype_reg   <= '0;
            bleft_reg   <= '0;
            baddr_reg   <= '0;
            initial_reg <= 1'b1;
            preload_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            start_reg   <= start_next;
            sample_reg  <= sample_next;
            acc_reg     <= acc_next;
            left_reg    <= left_next;
            btype_reg   <= btype_next;
            bleft_reg   <= bleft_next;
            baddr_reg   <= baddr_next;
            initial_reg <= initial_next;
            preload_reg <= preload_next;
            done_reg    <= done_next;
        end
    end

    a_silent_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> push.count == 2'd0)
        else $error("result produced after end of stream");

    a_pair_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |->
            (push.second.kind == KIND_END || push.second.kind == KIND_ERROR)
            && push.first.kind != KIND_END && push.first.kind != KIND_ERROR)
        else $error("two results per beat must be event then end/error");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_final_byte |=> done_reg)
        else $error("final byte did not close the stream");

endmodule

`default_nettype wire

### sv/vgmp_result_fifo.sv
// vgmp_result_fifo: small result queue taking up to two results per cycle, one out.
// Depends on vgmp_pkg and vgmp_if.
`default_nettype none

module vgmp_result_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  vgmp_pkg::push_t    push,
    output logic               room,
    vgmp_out_if.source         results
);
    import vgmp_pkg::*;

    localparam int unsigned Depth = FIFO_DEPTH;
    localparam int unsigned PtrW  = $clog2(Depth);
    localparam int unsigned CntW  = $clog2(Depth + 1);

    result_t           mem_reg [Depth];
    logic [PtrW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              pop;
    result_t           head;

    assign pop  = results.valid && results.ready;
    assign room = count_reg <= CntW'(Depth - 2);

    assign wr_next    = wr_reg + PtrW'(push.count);
    assign rd_next    = rd_reg + PtrW'(pop);
    assign count_next = count_reg + CntW'(push.count) - CntW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_reg + PtrW'(1)] <= push.second;
    end

    assign head                  = mem_reg[rd_reg];
    assign results.valid         = count_reg != '0;
    assign results.kind          = head.kind;
    assign results.sample_time   = head.sample_time;
    assign results.address       = head.address;
    assign results.value         = head.value;
    assign results.total_count   = head.total_count;
    assign results.error_code    = head.error_code;
    assign results.run_last      = head.run_last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> (count_reg + CntW'(push.count)) <= CntW'(Depth))
        else $error("push beyond free entries");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> count_reg == CntW'($past(count_reg) + CntW'($past(push.count)) - 1))
        else $error("queue fill count mismatch");

endmodule

`default_nettype wire

### sv/vgm_command_stream_parser_top.sv
// VGM command stream parser: takes one file byte per cycle on the bytes channel and
// returns register-write, RAM-write, RAM-preload, end and error results on the results
// channel. A byte is taken every cycle while the four-entry result queue has two free
// entries; results are queued and leave one per cycle while ready is high. Only the final
// byte can give two results (an event then the end or error), so a steady stream runs
// at one byte per cycle when the consumer keeps up. Events seen before an error result
// are to be discarded by the consumer. After an end or error, further bytes are taken
// and ignored until reset.
// Depends on vgmp_pkg, vgmp_if, vgmp_parser, vgmp_result_fifo.
`default_nettype none

module vgm_command_stream_parser_top #(
    parameter int unsigned RAM_BYTES = vgmp_pkg::RAM_BYTES_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    vgmp_in_if.sink     bytes,
    vgmp_out_if.source  results
);
    import vgmp_pkg::*;

    push_t push;
    logic  room;
    logic  accept;

    assign bytes.ready = room;
    assign accept      = bytes.valid && room;

    vgmp_parser #(
        .RAM_BYTES (RAM_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (bytes.in_byte),
        .is_final_byte (bytes.is_final_byte),
        .push          (push)
    );

    vgmp_result_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .results (results)
    );

endmodule

`default_nettype wire

### dv/vgm_command_stream_parser_top_tb.sv
// Self-checking bench for vgm_command_stream_parser_top: drives one VGM byte stream
// (header, directed commands, random commands, a random terminator) and checks every result.
// Depends on vgmp_pkg, vgmp_if and the parser RTL.

module vgm_command_stream_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vgmp_pkg::*;

    localparam logic [7:0]  CMD_END        = 8'h66;
    localparam logic [7:0]  CMD_WAIT_N     = 8'h61;
    localparam logic [7:0]  CMD_WAIT_735   = 8'h62;
    localparam logic [7:0]  CMD_WAIT_882   = 8'h63;
    localparam logic [7:0]  CMD_WAIT_SHORT = 8'h70;
    localparam logic [7:0]  CMD_REG_WRITE  = 8'hC5;
    localparam logic [7:0]  CMD_DATA_BLOCK = 8'h67;
    localparam logic [7:0]  BLK_MARKER     = 8'h66;
    localparam logic [7:0]  BLK_TYPE_RAM   = 8'hE0;
    localparam logic [31:0] VGM_MAGIC      = 32'h206D6756;
    localparam logic [31:0] OFS_TOTAL      = 32'h18;
    localparam logic [31:0] OFS_DATA       = 32'h34;
    localparam logic [31:0] MIN_END_POS    = 32'hFF;
    localparam longint unsigned RAM_SIZE   = RAM_BYTES_DEFAULT;
    localparam int STREAM_BYTES            = 1800;
    localparam int WATCHDOG_LIMIT          = 3000;
    localparam int HOLD_CYCLES             = 200;

    typedef enum logic [3:0] {
        PH_HEADER, PH_SKIP, PH_COMMAND, PH_WAIT_ARG, PH_REG_ARG, PH_BLK_MARK,
        PH_BLK_TYPE, PH_BLK_SIZE, PH_BLK_ADDR, PH_BLK_DATA, PH_TAIL
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       drain;
    } file_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte  = 8'h00;
    logic       drv_fin   = 1'b0;
    logic       res_ready = 1'b0;

    vgmp_in_if  bytes_if ();
    vgmp_out_if results_if ();

    assign bytes_if.valid         = drv_valid;
    assign bytes_if.in_byte       = drv_byte;
    assign bytes_if.is_final_byte = drv_fin;
    assign results_if.ready       = res_ready;

    vgm_command_stream_parser_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (results_if)
    );

    always #5 clk = ~clk;

    file_beat_t file_bytes [$];
    result_t    events_due [$];
    result_t    byte_events [$];

    int fault_count = 0;
    int bytes_taken = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int idle_cycles = 0;

    // parser shadow state
    logic [31:0]  file_pos    = '0;
    parse_phase_t phase       = PH_HEADER;
    logic [31:0]  hdr_total   = '0;
    logic [31:0]  cmd_start   = '0;
    logic [31:0]  sample_clk  = '0;
    logic [31:0]  field_acc   = '0;
    logic [2:0]   field_left  = '0;
    logic [7:0]   blk_type    = '0;
    logic [31:0]  blk_left    = '0;
    logic [31:0]  blk_addr    = '0;
    logic         in_initial  = 1'b1;
    logic         blk_preload = 1'b0;
    logic         stream_over = 1'b0;

    function automatic bit calm_window();
        return bytes_taken >= 900 && bytes_taken < 1200;
    endfunction

    function automatic string fmt_result(result_t r);
        return $sformatf("kind=%0d t=%08h addr=%08h val=%02h total=%08h err=%0d last=%0b",
                         r.kind, r.sample_time, r.address, r.value, r.total_count,
                         r.error_code, r.run_last);
    endfunction

    task automatic note_failure(input string what, input string detail);
        fault_count++;
        if (fault_count <= 10)
            $display("%s: %s", what, detail);
    endtask

    task automatic emit(input kind_t k, input logic [31:0] addr, input logic [7:0] val,
                        input logic [31:0] total, input err_t code);
        result_t r;
        r.kind          = k;
        r.sample_time   = sample_clk;
        r.address       = addr;
        r.value         = val;
        r.total_count   = total;
        r.error_code    = code;
        r.run_last      = 1'b0;
        if (byte_events.size() < 2)
            byte_events[byte_events.size()] = r;
    endtask

    task automatic abort_stream(input err_t code);
        emit(KIND_ERROR, '0, '0, '0, code);
        stream_over = 1'b1;
    endtask

    task automatic close_stream();
        emit(KIND_END, '0, '0, hdr_total, ERR_NONE);
        stream_over = 1'b1;
    endtask

    task automatic add_samples(input logic [31:0] n);
        logic [32:0] s;
        s = {1'b0, sample_clk} + {1'b0, n};
        sample_clk = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endtask

    task automatic run_command(input logic [7:0] b, input logic [31:0] idx);
        if (b == CMD_END) begin
            if (idx >= MIN_END_POS)
                close_stream();
            else
                phase = PH_TAIL;
        end else if (b == CMD_WAIT_N) begin
            phase = PH_WAIT_ARG;
            field_left = 3'd2;
            field_acc = '0;
        end else if (b == CMD_WAIT_735) begin
            add_samples(32'd735);
        end else if (b == CMD_WAIT_882) begin
            add_samples(32'd882);
        end else if ((b & 8'hF0) == CMD_WAIT_SHORT) begin
            add_samples({28'd0, b[3:0]} + 32'd1);
        end else if (b == CMD_REG_WRITE) begin
            in_initial = 1'b0;
            phase = PH_REG_ARG;
            field_left = 3'd3;
            field_acc = '0;
        end else if (b == CMD_DATA_BLOCK) begin
            phase = PH_BLK_MARK;
        end else begin
            abort_stream(ERR_COMMAND);
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [31:0] idx;
        logic [31:0] bw;
        idx = file_pos;
        bw = {24'd0, b};
        byte_events.delete();
        if (stream_over)
            return;
        if (file_pos != 32'hFFFF_FFFF)
            file_pos = file_pos + 32'd1;

        if (fin && idx < MIN_END_POS) begin
            abort_stream(ERR_NOT_VGM);
        end else begin
            case (phase)
                PH_HEADER:
                begin
                    if (idx < 32'd4 && b != VGM_MAGIC[8 * idx[1:0] +: 8]) begin
                        abort_stream(ERR_NOT_VGM);
                    end else begin
                        if (idx >= OFS_TOTAL && idx <= OFS_TOTAL + 32'd3)
                            hdr_total |= bw << (8 * (idx - OFS_TOTAL));
                        if (idx == OFS_DATA)
                            field_acc = bw;
                        else if (idx > OFS_DATA && idx <= OFS_DATA + 32'd3)
                            field_acc |= bw << (8 * (idx - OFS_DATA));
                        if (idx >= OFS_DATA + 32'd3) begin
                            cmd_start = OFS_DATA + field_acc;
                            field_acc = '0;
                            if (cmd_start < OFS_DATA + 32'd4)
                                abort_stream(ERR_START);
                            else if (cmd_start == OFS_DATA + 32'd4)
                                phase = PH_COMMAND;
                            else
                                phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (idx >= cmd_start) begin
                        phase = PH_COMMAND;
                        run_command(b, idx);
                    end
                end
                PH_COMMAND:
                begin
                    run_command(b, idx);
                end
                PH_WAIT_ARG:
                begin
                    field_acc |= bw << (8 * (2 - int'(field_left)));
                    field_left = field_left - 3'd1;
                    if (field_left == 3'd0) begin
                        add_samples(field_acc & 32'hFFFF);
                        phase = PH_COMMAND;
                    end
                end
                PH_REG_ARG:
                begin
                    if (field_left > 3'd1) begin
                        field_acc = ((field_acc << 8) | bw) & 32'hFFFF;
                        field_left = field_left - 3'd1;
                    end else begin
                        emit(KIND_REG_WRITE, field_acc & 32'hFFFF, b, '0, ERR_NONE);
                        field_left = 3'd0;
                        phase = PH_COMMAND;
                    end
                end
                PH_BLK_MARK:
                begin
                    if (b != BLK_MARKER)
                        abort_stream(ERR_BLOCK);
                    else
                        phase = PH_BLK_TYPE;
                end
                PH_BLK_TYPE:
                begin
                    blk_type = b;
                    phase = PH_BLK_SIZE;
                    field_left = 3'd4;
                    field_acc = '0;
                end
                PH_BLK_SIZE:
                begin
                    field_acc |= bw << (8 * (4 - int'(field_left)));
                    field_left = field_left - 3'd1;
                    if (field_left == 3'd0) begin
                        if (field_acc < 32'd4) begin
                            abort_stream(ERR_BLOCK_LENGTH);
                        end else begin
                            blk_left = field_acc - 32'd4;
                            phase = PH_BLK_ADDR;
                            field_left = 3'd4;
                            field_acc = '0;
                        end
                    end
                end
                PH_BLK_ADDR:
                begin
                    field_acc |= bw << (8 * (4 - int'(field_left)));
                    field_left = field_left - 3'd1;
                    if (field_left == 3'd0) begin
                        blk_addr = field_acc;
                        field_acc = '0;
                        blk_preload = 1'b0;
                        if (blk_type == BLK_TYPE_RAM) begin
                            if (in_initial && sample_clk == '0
                                && longint'(blk_addr) < RAM_SIZE
                                && longint'(blk_left) <= RAM_SIZE - longint'(blk_addr))
                                blk_preload = 1'b1;
                            else
                                in_initial = 1'b0;
                        end
                        phase = (blk_left == '0) ? PH_COMMAND : PH_BLK_DATA;
                    end
                end
                PH_BLK_DATA:
                begin
                    if (blk_type == BLK_TYPE_RAM)
                        emit(blk_preload ? KIND_RAM_PRELOAD : KIND_RAM_WRITE,
                             blk_addr, b, '0, ERR_NONE);
                    blk_addr = blk_addr + 32'd1;
                    blk_left = blk_left - 32'd1;
                    if (blk_left == '0)
                        phase = PH_COMMAND;
                end
                PH_TAIL:
                begin
                    if (idx >= MIN_END_POS)
                        close_stream();
                end
                default:
                begin
                    abort_stream(ERR_COMMAND);
                end
            endcase

            if (!stream_over && fin) begin
                case (phase)
                    PH_COMMAND, PH_SKIP, PH_TAIL:           close_stream();
                    PH_WAIT_ARG:                            abort_stream(ERR_WAIT);
                    PH_REG_ARG:                             abort_stream(ERR_REG_WRITE);
                    PH_BLK_MARK, PH_BLK_TYPE, PH_BLK_SIZE:  abort_stream(ERR_BLOCK);
                    PH_BLK_ADDR, PH_BLK_DATA:               abort_stream(ERR_BLOCK_LENGTH);
                    default:                                abort_stream(ERR_NOT_VGM);
                endcase
            end
        end

        if (byte_events.size() != 0)
            byte_events[byte_events.size() - 1].run_last = 1'b1;
        foreach (byte_events[k])
            events_due[events_due.size()] = byte_events[k];
    endtask

    // stream construction
    task automatic add_beat(input logic [7:0] data, input logic fin = 1'b0,
                            input logic drain = 1'b0);
        file_beat_t bt;
        bt.data  = data;
        bt.fin   = fin;
        bt.drain = drain;
        file_bytes[file_bytes.size()] = bt;
    endtask

    task automatic add_u32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            add_beat(v[8 * i +: 8]);
    endtask

    task automatic add_block(input logic [7:0] t, input logic [31:0] addr, input int n);
        add_beat(CMD_DATA_BLOCK);
        add_beat(BLK_MARKER);
        add_beat(t);
        add_u32(32'(n) + 32'd4);
        add_u32(addr);
        repeat (n)
            add_beat(8'($urandom_range(255)));
    endtask

    task automatic build_stream();
        logic [31:0] ofs;
        logic [31:0] total;
        logic [31:0] addr;
        logic [7:0]  t;
        int          sel;
        case ($urandom_range(3))
            0:       ofs = 32'd4;
            1:       ofs = 32'hCC;
            default: ofs = 32'($urandom_range(5, 32'h90));
        endcase
        case ($urandom_range(2))
            0:       total = '0;
            1:       total = 32'hFFFF_FFFF;
            default: total = $urandom;
        endcase
        for (int i = 0; i < 32'h38; i++) begin
            if (i < 4)
                add_beat(VGM_MAGIC[8 * i +: 8]);
            else if (i >= OFS_TOTAL && i < OFS_TOTAL + 4)
                add_beat(total[8 * (i - OFS_TOTAL) +: 8]);
            else if (i >= OFS_DATA)
                add_beat(ofs[8 * (i - OFS_DATA) +: 8]);
            else
                add_beat(8'($urandom_range(255)));
        end
        while (file_bytes.size() < OFS_DATA + ofs)
            add_beat(8'($urandom_range(255)));

        // preloads while at sample zero, then edge fits, skipped and non-fitting blocks
        add_block(BLK_TYPE_RAM, 32'd0, 3);
        add_block(BLK_TYPE_RAM, 32'(RAM_SIZE - 2), 2);
        add_block(8'h00, 32'h1234, 2);
        add_block(BLK_TYPE_RAM, 32'd0, 0);
        add_block(BLK_TYPE_RAM, 32'(RAM_SIZE - 1), 2);
        add_block(BLK_TYPE_RAM, 32'hFFFF_FFFF, 2);
        add_beat(CMD_WAIT_N); add_beat(8'hFF); add_beat(8'hFF);
        add_beat(CMD_WAIT_N); add_beat(8'h00); add_beat(8'h00);
        add_beat(CMD_WAIT_735);
        add_beat(CMD_WAIT_882);
        add_beat(CMD_WAIT_SHORT);
        add_beat(CMD_WAIT_SHORT | 8'h0F);
        add_beat(CMD_REG_WRITE); add_u32(32'h0000_0000 >> 8);
        file_bytes.pop_back();
        add_beat(CMD_REG_WRITE); add_beat(8'hFF); add_beat(8'hFF); add_beat(8'hFF);
        add_block(BLK_TYPE_RAM, 32'd0, 1);

        // random command body; the first beat waits for the pipeline to drain
        add_beat(CMD_WAIT_SHORT, 1'b0, 1'b1);
        while (file_bytes.size() < STREAM_BYTES - 20) begin
            sel = $urandom_range(99);
            if (sel < 20) begin
                add_beat(CMD_WAIT_SHORT | 8'($urandom_range(15)));
            end else if (sel < 30) begin
                add_beat(CMD_WAIT_N);
                add_beat(8'($urandom_range(255)));
                add_beat(8'($urandom_range(255)));
            end else if (sel < 35) begin
                add_beat(CMD_WAIT_735);
            end else if (sel < 40) begin
                add_beat(CMD_WAIT_882);
            end else if (sel < 70) begin
                add_beat(CMD_REG_WRITE);
                repeat (3)
                    add_beat(8'($urandom_range(255)));
            end else begin
                t = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : BLK_TYPE_RAM;
                addr = ($urandom_range(3) == 0) ? $urandom
                                                : 32'($urandom_range(0, 32'(RAM_SIZE)));
                add_block(t, addr, $urandom_range(0, 8));
            end
        end

        // terminator, preceded by a drain pause
        case ($urandom_range(9))
            0: add_beat(CMD_END, 1'b0, 1'b1);
            1: add_beat(CMD_END, 1'b1, 1'b1);
            2: add_beat(CMD_WAIT_735, 1'b1, 1'b1);
            3:
            begin
                add_beat(CMD_WAIT_N, 1'b0, 1'b1);
                add_beat(8'($urandom_range(255)), 1'b1);
            end
            4:
            begin
                add_beat(CMD_REG_WRITE, 1'b0, 1'b1);
                add_beat(8'($urandom_range(255)));
                add_beat(8'($urandom_range(255)), 1'b1);
            end
            5: add_beat(CMD_DATA_BLOCK, 1'b1, 1'b1);
            6:
            begin
                t = 8'($urandom_range(255));
                if (t == BLK_MARKER)
                    t = 8'h00;
                add_beat(CMD_DATA_BLOCK, 1'b0, 1'b1);
                add_beat(t);
            end
            7:
            begin
                add_beat(CMD_DATA_BLOCK, 1'b0, 1'b1);
                add_beat(BLK_MARKER);
                add_beat(BLK_TYPE_RAM);
                add_u32(32'($urandom_range(3)));
            end
            8:
            begin
                add_beat(CMD_DATA_BLOCK, 1'b0, 1'b1);
                add_beat(BLK_MARKER);
                add_beat(BLK_TYPE_RAM);
                add_u32(32'd7);
                add_u32($urandom);
                add_beat(8'($urandom_range(255)));
                add_beat(8'($urandom_range(255)), 1'b1);
            end
            default: add_beat(8'($urandom_range(0, 8'h5F)), 1'b0, 1'b1);
        endcase

        // bytes after the end of the stream are taken and ignored
        repeat (8)
            add_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n) begin : byte_driver
        file_beat_t bt;
        bit         go;
        if (!rst_n) begin
            drv_valid <= 1'b0;
            drv_byte  <= 8'h00;
            drv_fin   <= 1'b0;
        end else if (!drv_valid || bytes_if.ready) begin
            go = file_bytes.size() != 0;
            if (go && file_bytes[0].drain)
                go = !drv_valid && events_due.size() == 0;
            if (go && !calm_window() && $urandom_range(99) < 32)
                go = 1'b0;
            if (go) begin
                bt = file_bytes.pop_front();
                drv_valid <= 1'b1;
                drv_byte  <= bt.data;
                drv_fin   <= bt.fin;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // result consumer, with one long hold-off
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_taken >= 300) begin
            res_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            res_ready <= calm_window() || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge clk) begin
        if (rst_n && bytes_if.valid && bytes_if.ready) begin
            parse_byte(bytes_if.in_byte, bytes_if.is_final_byte);
            bytes_taken <= bytes_taken + 1;
        end
    end

    always @(posedge clk) begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n && results_if.valid && results_if.ready) begin
            got.kind          = kind_t'(results_if.kind);
            got.sample_time   = results_if.sample_time;
            got.address       = results_if.address;
            got.value         = results_if.value;
            got.total_count   = results_if.total_count;
            got.error_code    = err_t'(results_if.error_code);
            got.run_last      = results_if.run_last;
            if (events_due.size() == 0) begin
                note_failure("unexpected result", fmt_result(got));
            end else begin
                want = events_due.pop_front();
                if (got.kind !== want.kind || got.sample_time !== want.sample_time
                    || got.address !== want.address || got.value !== want.value
                    || got.total_count !== want.total_count
                    || got.error_code !== want.error_code || got.run_last !== want.run_last)
                    note_failure("result mismatch",
                                 {"exp ", fmt_result(want), " got ", fmt_result(got)});
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (bytes_if.valid && bytes_if.ready)
            || (results_if.valid && results_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("vgm_command_stream_parser_top_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        build_stream();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (file_bytes.size() != 0 || drv_valid)
            @(posedge clk);
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fault_count == 0 && events_due.size() == 0)
            $display("vgm_command_stream_parser_top_tb: clean");
        else
            $display("vgm_command_stream_parser_top_tb: errors");
        $finish;
    end

endmodule
